[hw/rtl/asit_pkg.sv]
// Shared types, constants and codes for the address session id table.
// No dependencies.
`timescale 1ns / 1ps

package asit_pkg;

  localparam int unsigned ENTRIES  = 64;
  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  localparam logic [31:0] HASH_MUL = 32'h5bd1e995;

  localparam logic [1:0] MODE_ADDR = 2'd0;
  localparam logic [1:0] MODE_ID   = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_NOTFND  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_TICK    = 3'd4;

  localparam logic [0:0] CFG_TIMEOUT = 1'd0;
  localparam logic [0:0] CFG_START   = 1'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] addr_lo;
    logic [63:0] addr_hi;
    logic [15:0] port;
    logic        is_v6;
    logic [31:0] lookup_sid;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic [63:0] out_addr_lo;
    logic [63:0] out_addr_hi;
    logic [15:0] out_port;
    logic        out_is_v6;
    logic [31:0] addr_hash;
    logic [6:0]  freed_count;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat, clear search state
    logic scan;      // read entry at idx (memory read issued)
    logic check;     // evaluate entry read last cycle
    logic hash_step; // advance hash unit one multiply
    logic finish;    // perform write-back and form result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_done;
  } dp_sts_t;

endpackage

[hw/rtl/asit_if.sv]
// Valid/ready channel interfaces carrying one input beat or one output beat.
// Depends on asit_pkg for the beat types.
`timescale 1ns / 1ps

interface asit_in_if import asit_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asit_out_if import asit_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/address_session_id_table.sv]
// Top level of the address session id table: controller, datapath, output register.
// Depends on asit_pkg, asit_if, asit_ctrl, asit_dp.
//
//  channel | dir | beat
//  in_     | in  | mode, address, port, family, session id
//  out_    | out | status, id, address, hash, freed count
//  cfg_    | in  | write-only: 0 timeout_ticks, 1 start_id
//
// The result is formed after the one-entry-a-cycle sweep (search or ageing) of all ENTRIES
// entries; the hash unit runs alongside. Reset clears valid marks and control.
// The next beat is taken once both result registers are empty; a stalled result holds.
`timescale 1ns / 1ps

module address_session_id_table import asit_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  asit_in_if.sink     in_ch,
  asit_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] idx;
  logic             in_fire, res_valid;
  out_beat_t        res;
  logic             ovalid_r;
  out_beat_t        odata_r;

  assign in_fire = in_ch.valid && in_ch.ready;

  asit_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(ovalid_r || res_valid), .sts,
    .in_ready(in_ch.ready), .idx, .cmd
  );

  asit_dp u_dp (
    .clk, .rst_n, .cmd, .idx, .in_data(in_ch.data),
    .cfg_we, .cfg_idx, .cfg_data, .sts, .res_valid, .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (res_valid) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
    if (res_valid) odata_r <= res;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_ch.ready) else $error("input taken while result pending");
  a_res_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !ovalid_r || out_ch.ready) else $error("result overwritten");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> odata_r.status <= ST_TICK) else $error("bad status");
`endif

endmodule

[hw/rtl/asit_ctrl.sv]
// Sequencer for the session table: load, entry sweep, hash steps, finish.
// Depends on asit_pkg.
`timescale 1ns / 1ps

module asit_ctrl import asit_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_busy,
  input  dp_sts_t          sts,
  output logic             in_ready,
  output logic [IDX_W-1:0] idx,
  output dp_cmd_t          cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             chk_r, chk_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    chk_nxt   = 1'b0;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE) && !out_busy;
    cmd.load  = in_fire;
    cmd.check = chk_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        cmd.scan      = 1'b1;
        cmd.hash_step = 1'b1;
        chk_nxt       = 1'b1;
        if (idx_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LAST: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done && !chk_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      chk_r   <= chk_nxt;
    end
  end

  assign idx = idx_r;

endmodule

[hw/rtl/asit_dp.sv]
// Datapath: entry and countdown memories, valid/alive flops, search, ageing, hash unit, result.
// Depends on asit_pkg.
`timescale 1ns / 1ps

module asit_dp import asit_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  logic [IDX_W-1:0] idx,
  input  in_beat_t         in_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_idx,
  input  logic [31:0]      cfg_data,
  output dp_sts_t          sts,
  output logic             res_valid,
  output out_beat_t        res
);

  // entry memory
  typedef struct packed {
    logic        v6;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] port;
    logic [31:0] sid;
  } entry_t;

  entry_t mem [ENTRIES];
  entry_t rd_r;
  logic [IDX_W-1:0] rd_idx_r;

  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] alive_r;
  logic [15:0]        cdown_r [ENTRIES];
  logic [15:0]        cd_rd_r;
  logic               cd_we;
  logic [IDX_W-1:0]   cd_waddr;
  logic [15:0]        cd_wdata;

  logic [15:0] timeout_r;
  logic [31:0] next_sid_r;

  in_beat_t    q_r;
  logic        found_r, free_ok_r;
  logic [IDX_W-1:0] found_idx_r, free_idx_r;
  entry_t      found_e_r;
  logic [6:0]  freed_r;

  logic is_tick, is_addr, is_id;
  assign is_tick = (q_r.mode == MODE_TICK);
  assign is_addr = (q_r.mode == MODE_ADDR);
  assign is_id   = (q_r.mode == MODE_ID);

  // hash unit: one multiply per cycle
  logic [3:0]  hstep_r;
  logic [1:0]  wsel_r, sub_r;
  logic [31:0] h_r, k_r, kw;
  logic [31:0] prod;
  logic [3:0]  hlast;

  logic [63:0] lo_m, hi_m;
  assign lo_m = in_data.is_v6 ? in_data.addr_lo : {32'd0, in_data.addr_lo[31:0]};
  assign hi_m = in_data.is_v6 ? in_data.addr_hi : 64'd0;

  // per word: k*=M ; k^=k>>24 ; k*=M ; h*=M ; h^=k  (3 steps), then final (1 step)
  assign hlast = q_r.is_v6 ? 4'd13 : 4'd4;
  assign sts.hash_done = (hstep_r == hlast);

  always_comb begin
    case (wsel_r)
      2'd0: kw = q_r.addr_lo[31:0];
      2'd1: kw = q_r.addr_lo[63:32];
      2'd2: kw = q_r.addr_hi[31:0];
      default: kw = q_r.addr_hi[63:32];
    endcase
  end

  logic       fin;
  assign fin  = (hstep_r == hlast - 4'd1);
  assign prod = (fin ? (h_r ^ (h_r >> 13)) :
                 sub_r == 2'd0 ? kw : sub_r == 2'd1 ? (k_r ^ (k_r >> 24)) : h_r) * HASH_MUL;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hstep_r <= '0;
      wsel_r  <= '0;
      sub_r   <= '0;
      h_r     <= {(in_data.is_v6 ? 16'd16 : 16'd4), in_data.port};
    end else if (cmd.hash_step && !sts.hash_done) begin
      hstep_r <= hstep_r + 1'b1;
      if (sub_r == 2'd2) begin
        sub_r  <= '0;
        wsel_r <= wsel_r + 1'b1;
      end else begin
        sub_r <= sub_r + 1'b1;
      end
      if (fin)                 h_r <= prod ^ (prod >> 15);
      else if (sub_r == 2'd2)  h_r <= prod ^ k_r;
      else                     k_r <= prod;
    end
  end

  // tick ageing of the entry read last cycle
  logic tick_live, tick_exp, tick_free;
  assign tick_live = cmd.check && is_tick && valid_r[rd_idx_r];
  assign tick_exp  = tick_live && (cd_rd_r <= 16'd1);
  assign tick_free = tick_exp && !alive_r[rd_idx_r];

  always_comb begin
    cd_we    = 1'b0;
    cd_waddr = rd_idx_r;
    cd_wdata = cd_rd_r - 16'd1;
    if (cmd.finish && is_addr && !found_r && free_ok_r) begin
      cd_we    = 1'b1;
      cd_waddr = free_idx_r;
      cd_wdata = timeout_r;
    end else if (tick_live) begin
      cd_we = 1'b1;
      if (tick_exp) cd_wdata = timeout_r;
    end
  end

  // memory read
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_r     <= mem[idx];
      cd_rd_r  <= cdown_r[idx];
      rd_idx_r <= idx;
    end
    if (cd_we) cdown_r[cd_waddr] <= cd_wdata;
  end

  logic match;
  always_comb begin
    if (q_r.mode == MODE_ID)
      match = valid_r[rd_idx_r] && (rd_r.sid == q_r.lookup_sid);
    else
      match = valid_r[rd_idx_r] && rd_r.v6 == q_r.is_v6 && rd_r.port == q_r.port &&
              rd_r.lo == q_r.addr_lo && rd_r.hi == q_r.addr_hi;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r.mode       <= in_data.mode;
      q_r.addr_lo    <= lo_m;
      q_r.addr_hi    <= hi_m;
      q_r.port       <= in_data.port;
      q_r.is_v6      <= in_data.is_v6;
      q_r.lookup_sid <= in_data.lookup_sid;
    end
    if (cmd.finish && is_addr && !found_r && free_ok_r) begin
      mem[free_idx_r] <= '{v6: q_r.is_v6, lo: q_r.addr_lo, hi: q_r.addr_hi,
                           port: q_r.port, sid: next_sid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      timeout_r  <= 16'd60;
      next_sid_r <= 32'd0;
      found_r    <= 1'b0;
      free_ok_r  <= 1'b0;
      freed_r    <= '0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= cmd.finish;
      if (cfg_we && cfg_idx == CFG_TIMEOUT) timeout_r <= cfg_data[15:0];
      if (cfg_we && cfg_idx == CFG_START)   next_sid_r <= cfg_data;
      if (cmd.load) begin
        found_r   <= 1'b0;
        free_ok_r <= 1'b0;
        freed_r   <= '0;
      end else if (cmd.check) begin
        if (match && !found_r) begin
          found_r     <= 1'b1;
          found_idx_r <= rd_idx_r;
          found_e_r   <= rd_r;
        end
        if (!valid_r[rd_idx_r] && !free_ok_r) begin
          free_ok_r  <= 1'b1;
          free_idx_r <= rd_idx_r;
        end
        if (tick_free) begin
          valid_r[rd_idx_r] <= 1'b0;
          if (freed_r != 7'd127) freed_r <= freed_r + 7'd1;
        end
      end
      if (cmd.finish) begin
        if (is_addr && !found_r && free_ok_r) begin
          valid_r[free_idx_r] <= 1'b1;
          next_sid_r          <= next_sid_r + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_exp && alive_r[rd_idx_r]) alive_r[rd_idx_r] <= 1'b0;
    if (cmd.finish) begin
      if ((is_addr || is_id) && found_r) alive_r[found_idx_r] <= 1'b1;
      if (is_addr && !found_r && free_ok_r) alive_r[free_idx_r] <= 1'b0;
      res.addr_hash   <= h_r;
      res.result_id   <= '0;
      res.out_addr_lo <= '0;
      res.out_addr_hi <= '0;
      res.out_port    <= '0;
      res.out_is_v6   <= 1'b0;
      res.freed_count <= '0;
      res.status      <= ST_NOTFND;
      if (is_addr) begin
        if (found_r) begin
          res.status    <= ST_HIT;
          res.result_id <= found_e_r.sid;
        end else if (free_ok_r) begin
          res.status    <= ST_NEW;
          res.result_id <= next_sid_r;
        end else begin
          res.status <= ST_FULL;
        end
      end else if (is_id) begin
        if (found_r) begin
          res.status      <= ST_HIT;
          res.result_id   <= found_e_r.sid;
          res.out_addr_lo <= found_e_r.lo;
          res.out_addr_hi <= found_e_r.hi;
          res.out_port    <= found_e_r.port;
          res.out_is_v6   <= found_e_r.v6;
        end
      end else if (is_tick) begin
        res.status      <= ST_TICK;
        res.freed_count <= freed_r;
      end
    end
  end

endmodule

[test/tb_asit_pkg.sv]
// Testbench-side helpers for the address session id table: the session table predictor.
// Depends on asit_pkg for beat types and codes.
`timescale 1ns / 1ps

package tb_asit_pkg;
  import asit_pkg::*;

  class session_table_sb;
    bit          valid_q [ENTRIES];
    bit          fam_q   [ENTRIES];
    logic [63:0] lo_q    [ENTRIES];
    logic [63:0] hi_q    [ENTRIES];
    logic [15:0] port_q  [ENTRIES];
    logic [31:0] sid_q   [ENTRIES];
    bit          alive_q [ENTRIES];
    logic [15:0] cnt_q   [ENTRIES];
    logic [31:0] next_sid;
    logic [15:0] timeout;
    out_beat_t   pending_results [$];
    int          n_mismatch;
    int          n_checked;

    function new();
      timeout    = 16'd60;
      next_sid   = 32'd0;
      n_mismatch = 0;
      n_checked  = 0;
      foreach (valid_q[i]) valid_q[i] = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [31:0] val);
      if (idx == CFG_TIMEOUT) timeout = val[15:0];
      else begin
        next_sid = val;
      end
    endfunction

    function logic [31:0] mix(logic [31:0] h, logic [31:0] k);
      k = k * HASH_MUL;
      k = k ^ (k >> 24);
      k = k * HASH_MUL;
      h = h * HASH_MUL;
      return h ^ k;
    endfunction

    function logic [31:0] hash_addr(logic [63:0] lo, logic [63:0] hi, logic [15:0] p, bit v6);
      logic [31:0] h;
      h = {(v6 ? 16'd16 : 16'd4), p};
      h = mix(h, lo[31:0]);
      if (v6) begin
        h = mix(h, lo[63:32]);
        h = mix(h, hi[31:0]);
        h = mix(h, hi[63:32]);
      end
      h = h ^ (h >> 13);
      h = h * HASH_MUL;
      h = h ^ (h >> 15);
      return h;
    endfunction

    function void note_input(in_beat_t b);
      out_beat_t   r;
      logic [63:0] lo, hi;
      int          hit, free_slot;
      r = '0;
      lo = b.is_v6 ? b.addr_lo : {32'd0, b.addr_lo[31:0]};
      hi = b.is_v6 ? b.addr_hi : 64'd0;
      hit = -1;
      free_slot = -1;
      r.status = ST_NOTFND;
      if (b.mode == MODE_ADDR) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!valid_q[i]) begin
            if (free_slot < 0) free_slot = i;
          end else if (hit < 0 && fam_q[i] == b.is_v6 && port_q[i] == b.port &&
                       lo_q[i] == lo && hi_q[i] == hi) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          alive_q[hit] = 1;
          r.status = ST_HIT;
          r.result_id = sid_q[hit];
        end else if (free_slot >= 0) begin
          valid_q[free_slot] = 1;
          fam_q[free_slot] = b.is_v6;
          lo_q[free_slot] = lo;
          hi_q[free_slot] = hi;
          port_q[free_slot] = b.port;
          sid_q[free_slot] = next_sid;
          alive_q[free_slot] = 0;
          cnt_q[free_slot] = timeout;
          r.result_id = next_sid;
          next_sid = next_sid + 1;
          r.status = ST_NEW;
        end else begin
          r.status = ST_FULL;
        end
      end else if (b.mode == MODE_ID) begin
        for (int i = 0; i < ENTRIES; i++)
          if (hit < 0 && valid_q[i] && sid_q[i] == b.lookup_sid) hit = i;
        if (hit >= 0) begin
          alive_q[hit] = 1;
          r.status = ST_HIT;
          r.result_id = sid_q[hit];
          r.out_addr_lo = lo_q[hit];
          r.out_addr_hi = hi_q[hit];
          r.out_port = port_q[hit];
          r.out_is_v6 = fam_q[hit];
        end
      end else if (b.mode == MODE_TICK) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!valid_q[i]) continue;
          if (cnt_q[i] > 1) cnt_q[i] = cnt_q[i] - 1;
          else if (!alive_q[i]) begin
            valid_q[i] = 0;
            if (r.freed_count < 127) r.freed_count = r.freed_count + 1;
          end else begin
            alive_q[i] = 0;
            cnt_q[i] = timeout;
          end
        end
        r.status = ST_TICK;
      end
      r.addr_hash = hash_addr(lo, hi, b.port, b.is_v6);
      pending_results.push_back(r);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp = pending_results.pop_front();
      n_checked++;
      if (got !== exp) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("mismatch: status %0d/%0d id %h/%h hash %h/%h freed %0d/%0d",
                   exp.status, got.status, exp.result_id, got.result_id,
                   exp.addr_hash, got.addr_hash, exp.freed_count, got.freed_count);
          $display("  addr %h_%h/%h_%h port %h/%h v6 %b/%b",
                   exp.out_addr_hi, exp.out_addr_lo, got.out_addr_hi, got.out_addr_lo,
                   exp.out_port, got.out_port, exp.out_is_v6, got.out_is_v6);
        end
      end
    endfunction
  endclass
endpackage

[test/tb_top.sv]
// Top of the address session id table test: clock, reset, beat drivers and stimulus.
// Depends on asit_pkg, asit_if, tb_asit_pkg and the address_session_id_table RTL.
`timescale 1ns / 1ps

module tb_top;
  import asit_pkg::*;
  import tb_asit_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [0:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  bit          quiet = 0;
  int          n_sent = 0;
  int          rdy_idle = 0;

  asit_in_if  in_ch ();
  asit_out_if out_ch ();

  session_table_sb sb = new();

  // known address pool so address lookups hit often
  logic [63:0] pool_lo [16];
  logic [63:0] pool_hi [16];
  logic [15:0] pool_port [16];
  bit          pool_v6 [16];

  always #10 clk = ~clk;

  address_session_id_table u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // sink drops ready at random while quiet is clear
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else if (rdy_idle > 0) begin
      out_ch.ready <= 0;
      rdy_idle <= rdy_idle - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 0;
      rdy_idle <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1;
    end
  end

  task automatic send_beat(in_beat_t b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(b);
    n_sent++;
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic in_beat_t rand_beat();
    in_beat_t     b;
    logic [191:0] rnd;
    int           k;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    b = rnd[$bits(in_beat_t)-1:0];
    k = $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        b.mode = MODE_ADDR;
        if ($urandom_range(0, 3) != 0) begin
          b.addr_lo = pool_lo[k];
          b.addr_hi = pool_hi[k];
          b.port = pool_port[k];
          b.is_v6 = pool_v6[k];
        end
      end
      5, 6: begin
        b.mode = MODE_ID;
        if ($urandom_range(0, 3) != 0) b.lookup_sid = sb.next_sid - $urandom_range(1, 40);
      end
      7, 8: b.mode = MODE_TICK;
      default: b.mode = 2'd3;
    endcase
    return b;
  endfunction

  function automatic in_beat_t mk(logic [1:0] m, logic [63:0] lo, logic [63:0] hi,
                                  logic [15:0] p, bit v6, logic [31:0] sid);
    in_beat_t b;
    b.mode = m;
    b.addr_lo = lo;
    b.addr_hi = hi;
    b.port = p;
    b.is_v6 = v6;
    b.lookup_sid = sid;
    return b;
  endfunction

  initial begin
    in_beat_t b;
    foreach (pool_lo[i]) begin
      pool_lo[i] = {$urandom, $urandom};
      pool_hi[i] = {$urandom, $urandom};
      pool_port[i] = 16'($urandom);
      pool_v6[i] = 1'($urandom_range(0, 1));
    end
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, both families, all modes, repeat ids, full table
    write_reg(CFG_TIMEOUT, 32'd2);
    write_reg(CFG_START, 32'hFFFF_FFFE);
    send_beat(mk(MODE_ADDR, '1, '1, 16'hFFFF, 1'b1, '1));
    send_beat(mk(MODE_ADDR, '1, '1, 16'hFFFF, 1'b0, '0));
    send_beat(mk(MODE_ADDR, 64'hABCD_0000_FFFF_FFFF, '0, 16'hFFFF, 1'b0, '0));
    send_beat(mk(MODE_ADDR, '0, '0, '0, 1'b0, '0));
    send_beat(mk(MODE_ADDR, '0, '0, '0, 1'b1, '0));
    send_beat(mk(MODE_ADDR, '1, '1, 16'hFFFF, 1'b1, '0));
    send_beat(mk(MODE_ID, '0, '0, '0, 1'b0, 32'hFFFF_FFFF));
    send_beat(mk(MODE_ID, '0, '0, '0, 1'b0, 32'h0));
    send_beat(mk(MODE_ID, '0, '0, '0, 1'b0, 32'h1234_5678));
    send_beat(mk(2'd3, '1, '1, 16'hFFFF, 1'b1, '1));
    repeat (4) send_beat(mk(MODE_TICK, '1, '0, 16'h1, 1'b0, '0));
    drain();
    write_reg(CFG_TIMEOUT, 32'd0);
    write_reg(CFG_START, 32'd0);
    for (int i = 0; i < ENTRIES + 2; i++)
      send_beat(mk(MODE_ADDR, 64'(i), '0, 16'h50, 1'b0, '0));
    send_beat(mk(MODE_ADDR, 64'd3, '0, 16'h50, 1'b0, '0));
    send_beat(mk(MODE_TICK, '0, '0, '0, 1'b0, '0));
    send_beat(mk(MODE_TICK, '0, '0, '0, 1'b0, '0));
    drain();

    // random phases across register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_reg(CFG_TIMEOUT, 32'd65535);
        1: write_reg(CFG_TIMEOUT, 32'd1);
        2: write_reg(CFG_TIMEOUT, $urandom_range(2, 8));
        3: write_reg(CFG_START, 32'hFFFF_FFF0);
        default: write_reg(CFG_TIMEOUT, $urandom_range(1, 5));
      endcase
      if (ph == 2) write_reg(CFG_START, $urandom);
      if (ph == 4) quiet = 1;
      for (int n = 0; n < 135; n++) begin
        send_beat(rand_beat());
        if (n == 75 && ph == 1) begin
          while (sb.pending_results.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("sent %0d beats, checked %0d results across %0d register settings",
             n_sent, sb.n_checked, 7);
    if (sb.n_mismatch == 0 && sb.pending_results.size() == 0)
      $display("address_session_id_table test passed");
    else
      $display("address_session_id_table test failed");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("address_session_id_table test failed");
    $finish;
  end
endmodule
